// ----- design/adt_pkg.sv -----
// Package for the dual down-counter timer: beat payload types, operation codes,
// register offsets, control bit positions and the peripheral ID table.
// Depends on nothing; every design file imports it.
package adt_pkg;

   // Operation codes carried in the op field of a request beat.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Per-timer register offsets, taken from address bits 4:2.
   localparam logic [2:0] REG_LOAD    = 3'd0;
   localparam logic [2:0] REG_VALUE   = 3'd1;
   localparam logic [2:0] REG_CONTROL = 3'd2;
   localparam logic [2:0] REG_INTCLR  = 3'd3;
   localparam logic [2:0] REG_RIS     = 3'd4;
   localparam logic [2:0] REG_MIS     = 3'd5;
   localparam logic [2:0] REG_BGLOAD  = 3'd6;

   // Integration test registers, as address bits 7:2 in the top page.
   localparam logic [5:0] REG_ITCR = 6'h00;
   localparam logic [5:0] REG_ITOP = 6'h01;

   // Control register bit positions and the mask of implemented bits.
   localparam int unsigned CTL_ONESHOT = 0;
   localparam int unsigned CTL_SIZE    = 1;
   localparam int unsigned CTL_INTEN   = 5;
   localparam int unsigned CTL_MODE    = 6;
   localparam int unsigned CTL_ENABLE  = 7;
   localparam logic [7:0]  CTL_VALID   = 8'hef;
   localparam logic [7:0]  CTL_RESET   = 8'h20;

   // Request and response beats.
   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [31:0] wdata;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq_one;
      logic        irq_two;
      logic        irq_combined;
   } rsp_payload_type;

   // Peripheral ID registers at 0xfd0 through 0xffc, indexed by word.
   function automatic logic [7:0] id_value(input logic [3:0] idx);
      logic [7:0] v;
      case (idx)
         4'd0:    v = 8'h04;
         4'd4:    v = 8'h23;
         4'd5:    v = 8'hb8;
         4'd6:    v = 8'h1b;
         4'd8:    v = 8'h0d;
         4'd9:    v = 8'hf0;
         4'd10:   v = 8'h05;
         4'd11:   v = 8'hb1;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ----- design/apb_dual_down_counter_timer_top.sv -----
// Dual down-counter timer with a word-addressed register bus.
// Single module; uses adt_pkg for beat types, codes and the ID table.
//
//   channel  | direction | payload           | handshake
//   req_     | in        | op, addr, wdata   | req_valid / req_ready
//   rsp_     | out       | rdata, irq_*      | rsp_valid / rsp_ready
//
// A request is held in the input register and then moves to the result
// register, which drives its response onto the port.
// One request is taken every cycle while responses are taken.
// The timer state is updated as a request moves from the input register into
// the result register, so the next request always sees the previous one's effect.
// Reset is synchronous and returns both timers to their documented reset values.
// A stalled response holds the result register and then the input register;
// req_ready drops only when both are full and rsp_ready is low.
module apb_dual_down_counter_timer_top #(
   parameter int unsigned NUM_TIMERS = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  adt_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output adt_pkg::rsp_payload_type rsp_payload
);
   import adt_pkg::*;

   // Pipeline registers.
   logic            in_valid_ff;
   req_payload_type in_beat_ff;
   logic            out_valid_ff;
   rsp_payload_type out_beat_ff;
   rsp_payload_type out_beat_in;
   logic            advance;

   // Timer state.
   logic [31:0] count_ff [2];
   logic [31:0] count_in [2];
   logic [31:0] load_ff [2];
   logic [31:0] load_in [2];
   logic [7:0]  ctl_ff [2];
   logic [7:0]  ctl_in [2];
   logic [1:0]  raw_ff;
   logic [1:0]  raw_in;
   logic [7:0]  psc_ff [2];
   logic [7:0]  psc_in [2];
   logic [1:0]  done_ff;
   logic [1:0]  done_in;
   logic        test_mode_ff;
   logic        test_mode_in;
   logic [1:0]  test_out_ff;
   logic [1:0]  test_out_in;
   logic [1:0]  irq;

   // Decoded request fields.
   logic [1:0]  op;
   logic [11:0] a;
   logic [31:0] v;
   logic        timer_page;
   logic        top_page;

   // Flow control: the input register moves on when the result slot is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   assign op = in_beat_ff.op;
   assign a  = {in_beat_ff.addr[11:2], 2'b00};
   assign v  = in_beat_ff.wdata;
   assign timer_page = (a[11:6] == 6'd0);
   assign top_page   = (a[11:8] == 4'hf);

   // Next timer state for the beat in the input register.
   always_comb begin
      logic [31:0] low;
      logic [31:0] dec;
      logic [31:0] mask;
      logic [7:0]  pnext;
      logic [7:0]  pmask;
      logic [7:0]  nc;
      logic        present;
      logic        hit;
      test_mode_in = test_mode_ff;
      test_out_in  = test_out_ff;
      if (op == OP_WRITE && top_page && a[7:2] == REG_ITCR) begin
         test_mode_in = v[0];
      end
      if (op == OP_WRITE && top_page && a[7:2] == REG_ITOP) begin
         test_out_in = v[1:0];
      end
      for (int t = 0; t < 2; t++) begin
         count_in[t] = count_ff[t];
         load_in[t]  = load_ff[t];
         ctl_in[t]   = ctl_ff[t];
         raw_in[t]   = raw_ff[t];
         psc_in[t]   = psc_ff[t];
         done_in[t]  = done_ff[t];
         present = (t < NUM_TIMERS);
         hit = present && timer_page && (a[5] == t[0]);
         mask = ctl_ff[t][CTL_SIZE] ? 32'hffff_ffff : 32'h0000_ffff;
         low  = count_ff[t] & mask;
         dec  = (low - 32'd1) & mask;
         nc   = v[7:0] & CTL_VALID;
         pnext = psc_ff[t] + 8'd1;
         case (ctl_ff[t][3:2])
            2'd0:    pmask = 8'h00;
            2'd1:    pmask = 8'h0f;
            default: pmask = 8'hff;
         endcase
         case (op)
            OP_TICK: begin
               if (present && ctl_ff[t][CTL_ENABLE] && !done_ff[t]) begin
                  psc_in[t] = pnext;
                  if ((pnext & pmask) == 8'h00) begin
                     // One count step on the low 16 or all 32 bits.
                     if (low != 32'd0) begin
                        low = dec;
                        if (dec == 32'd0) begin
                           raw_in[t] = 1'b1;
                           if (ctl_ff[t][CTL_ONESHOT]) begin
                              done_in[t] = 1'b1;
                           end
                        end
                     end else if (ctl_ff[t][CTL_ONESHOT]) begin
                        done_in[t] = 1'b1;
                     end else if (ctl_ff[t][CTL_MODE]) begin
                        low = load_ff[t] & mask;
                     end else begin
                        low = mask;
                     end
                     count_in[t] = (count_ff[t] & ~mask) | low;
                  end
               end
            end
            OP_WRITE: begin
               if (hit) begin
                  case (a[4:2])
                     REG_LOAD: begin
                        load_in[t]  = v;
                        count_in[t] = v;
                        done_in[t]  = 1'b0;
                        psc_in[t]   = 8'h00;
                     end
                     REG_BGLOAD: begin
                        load_in[t] = v;
                     end
                     REG_CONTROL: begin
                        if (((nc ^ ctl_ff[t]) & 8'h0c) != 8'h00) begin
                           psc_in[t] = 8'h00;
                        end
                        if (nc[CTL_ENABLE]) begin
                           done_in[t] = 1'b0;
                        end
                        ctl_in[t] = nc;
                     end
                     REG_INTCLR: begin
                        raw_in[t] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
         // Interrupt outputs as they stand after this beat.
         irq[t] = test_mode_in ? test_out_in[t] : (raw_in[t] && ctl_in[t][CTL_INTEN]);
      end
   end

   // Read data for the beat in the input register.
   always_comb begin
      logic [31:0] rd;
      logic [1:0]  ts;
      rd = 32'd0;
      ts = {1'b0, a[5]};
      if (op == OP_READ) begin
         if (top_page) begin
            if (a[7:2] == REG_ITCR) begin
               rd = {31'd0, test_mode_ff};
            end else if (a[7:4] >= 4'hd) begin
               rd = {24'd0, id_value(a[5:2] - 4'd4)};
            end
         end else if (timer_page && (32'(ts) < NUM_TIMERS)) begin
            case (a[4:2])
               REG_LOAD, REG_BGLOAD: rd = load_ff[a[5]];
               REG_VALUE:            rd = count_ff[a[5]];
               REG_CONTROL:          rd = {24'd0, ctl_ff[a[5]]};
               REG_RIS:              rd = {31'd0, raw_ff[a[5]]};
               REG_MIS: rd = {31'd0, raw_ff[a[5]] && ctl_ff[a[5]][CTL_INTEN]};
               default:              rd = 32'd0;
            endcase
         end
      end
      out_beat_in.rdata        = rd;
      out_beat_in.irq_one      = irq[0];
      out_beat_in.irq_two      = irq[1];
      out_beat_in.irq_combined = irq[0] | irq[1];
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_beat_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_beat_ff <= out_beat_in;
      end
   end

   // Timer state registers, updated once per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < 2; t++) begin
            count_ff[t] <= 32'hffff_ffff;
            load_ff[t]  <= 32'd0;
            ctl_ff[t]   <= CTL_RESET;
            psc_ff[t]   <= 8'h00;
         end
         raw_ff       <= 2'b00;
         done_ff      <= 2'b00;
         test_mode_ff <= 1'b0;
         test_out_ff  <= 2'b00;
      end else if (advance) begin
         for (int t = 0; t < 2; t++) begin
            count_ff[t] <= count_in[t];
            load_ff[t]  <= load_in[t];
            ctl_ff[t]   <= ctl_in[t];
            psc_ff[t]   <= psc_in[t];
         end
         raw_ff       <= raw_in;
         done_ff      <= done_in;
         test_mode_ff <= test_mode_in;
         test_out_ff  <= test_out_in;
      end
   end

   // The combined interrupt is always the OR of the two timer outputs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.irq_combined == (rsp_payload.irq_one | rsp_payload.irq_two)))
      else $error("combined interrupt disagrees with timer outputs");

   // A held beat in the input register is never dropped.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat lost while stalled");

   // Only a bus write can change a load value.
   assert property (@(posedge clock) disable iff (reset)
      !(advance && op == OP_WRITE) |=> ($stable(load_ff[0]) && $stable(load_ff[1])))
      else $error("load value changed without a write");

   // An absent second timer never raises its raw interrupt.
   assert property (@(posedge clock) disable iff (reset)
      (NUM_TIMERS < 2) |-> !raw_ff[1])
      else $error("absent timer raised an interrupt");

endmodule
